// File: hw/rtl/ess_pkg.sv
// ess_pkg: shared constants, codes and types for the ellipse span solver
// no dependencies
package ess_pkg;

  localparam int ESS_COORD_BITS = 12;
  localparam int ESS_REG_IDX_BITS = 2;

  // register indexes on the config port
  localparam logic [ESS_REG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [ESS_REG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [ESS_REG_IDX_BITS-1:0] REG_RADIUS_X = 2'd2;
  localparam logic [ESS_REG_IDX_BITS-1:0] REG_RADIUS_Y = 2'd3;

  // opcodes
  localparam logic OP_SOLVE_X = 1'b0;
  localparam logic OP_SOLVE_Y = 1'b1;

  // solution counts
  localparam logic [1:0] CNT_NONE    = 2'd0;
  localparam logic [1:0] CNT_TANGENT = 2'd1;
  localparam logic [1:0] CNT_CHORD   = 2'd2;

  // status flags that ride along with the quotient
  typedef struct packed {
    logic neg;        // radicand term below zero
    logic near_zero;  // negative quotient truncates to zero
  } ess_flags_t;

endpackage

// File: hw/rtl/ess_in_if.sv
// ess_in_if: query channel, valid/ready with opcode and known coordinate
// depends on ess_pkg
interface ess_in_if #(parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] coordinate;
  modport source(output valid, opcode, coordinate, input ready);
  modport sink(input valid, opcode, coordinate, output ready);
endinterface

// File: hw/rtl/ess_out_if.sv
// ess_out_if: result channel, valid/ready with count and two values
// depends on ess_pkg
interface ess_out_if #(parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 value_count;
  logic signed [COORD_BITS:0] first_value;
  logic signed [COORD_BITS:0] second_value;
  modport source(output valid, value_count, first_value, second_value, input ready);
  modport sink(input valid, value_count, first_value, second_value, output ready);
endinterface

// File: hw/rtl/ess_cfg_if.sv
// ess_cfg_if: register write channel, valid/ready with index and data
// depends on ess_pkg
interface ess_cfg_if #(parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS);
  import ess_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [ESS_REG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/ess_front.sv
// ess_front: five stages from query to dividend, divisor and flags
// depends on ess_pkg
module ess_front #(
  parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic                            in_opcode,
  input  logic signed [COORD_BITS-1:0]    in_coord,
  input  logic signed [COORD_BITS-1:0]    cfg_cx,
  input  logic signed [COORD_BITS-1:0]    cfg_cy,
  input  logic [COORD_BITS-2:0]           cfg_rx,
  input  logic [COORD_BITS-2:0]           cfg_ry,
  output logic                            out_valid,
  output logic [4*COORD_BITS-2:0]         out_num,
  output logic [2*COORD_BITS-3:0]         out_den,
  output logic signed [COORD_BITS-1:0]    out_cout,
  output ess_pkg::ess_flags_t             out_flags
);
  import ess_pkg::*;
  localparam int N = COORD_BITS;

  logic [4:0] vld_r;

  // stage 1
  logic signed [N:0]   d1_r;
  logic [N-2:0]        rdiv1_r, rmul1_r;
  logic signed [N-1:0] cout1_r;
  // stage 2
  logic [2*N:0]        dsq2_r;
  logic [2*N-3:0]      den2_r, rm2_r;
  logic signed [N-1:0] cout2_r;
  // stage 3
  logic [2*N:0]        ae3_r;
  logic                neg3_r;
  logic [2*N-3:0]      den3_r, rm3_r;
  logic signed [N-1:0] cout3_r;
  // stage 4
  logic [4*N-2:0]      m4_r;
  logic                neg4_r;
  logic [2*N-3:0]      den4_r;
  logic signed [N-1:0] cout4_r;
  // stage 5
  logic [4*N-2:0]      num5_r;
  logic [2*N-3:0]      den5_r;
  logic signed [N-1:0] cout5_r;
  ess_flags_t          flags5_r;

  logic signed [N-1:0] known_ctr, cout_sel;
  logic [N-2:0]        rdiv_sel, rmul_sel, rx_eff, ry_eff;
  logic signed [2*N+1:0] dprod;
  logic [2*N-3:0]      den_w, rm_w;
  logic [2*N+1:0]      e_w, e_neg;
  logic [4*N-2:0]      m_w;

  always_comb begin
    // a zero radius acts as one
    rx_eff = (cfg_rx == '0) ? (N-1)'(1) : cfg_rx;
    ry_eff = (cfg_ry == '0) ? (N-1)'(1) : cfg_ry;
    if (in_opcode == OP_SOLVE_X) begin
      known_ctr = cfg_cy;
      cout_sel  = cfg_cx;
      rdiv_sel  = ry_eff;
      rmul_sel  = rx_eff;
    end else begin
      known_ctr = cfg_cx;
      cout_sel  = cfg_cy;
      rdiv_sel  = rx_eff;
      rmul_sel  = ry_eff;
    end
    dprod = d1_r * d1_r;
    den_w = rdiv1_r * rdiv1_r;
    rm_w  = rmul1_r * rmul1_r;
    e_w   = {4'b0, den2_r} - {1'b0, dsq2_r};
    e_neg = -e_w;
    m_w   = rm3_r * ae3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r     <= {in_coord[N-1], in_coord} - {known_ctr[N-1], known_ctr};
      rdiv1_r  <= rdiv_sel;
      rmul1_r  <= rmul_sel;
      cout1_r  <= cout_sel;

      dsq2_r   <= dprod[2*N:0];
      den2_r   <= den_w;
      rm2_r    <= rm_w;
      cout2_r  <= cout1_r;

      neg3_r   <= e_w[2*N+1];
      ae3_r    <= e_w[2*N+1] ? e_neg[2*N:0] : e_w[2*N:0];
      den3_r   <= den2_r;
      rm3_r    <= rm2_r;
      cout3_r  <= cout2_r;

      m4_r     <= m_w;
      neg4_r   <= neg3_r;
      den4_r   <= den3_r;
      cout4_r  <= cout3_r;

      // negative side only needs to know whether the quotient truncates to zero
      flags5_r.neg       <= neg4_r;
      flags5_r.near_zero <= m4_r < {{(2*N+1){1'b0}}, den4_r};
      num5_r   <= neg4_r ? '0 : m4_r;
      den5_r   <= den4_r;
      cout5_r  <= cout4_r;
    end
  end

  assign out_valid = vld_r[4];
  assign out_num   = num5_r;
  assign out_den   = den5_r;
  assign out_cout  = cout5_r;
  assign out_flags = flags5_r;

endmodule

// File: hw/rtl/ess_div.sv
// ess_div: pipelined restoring divider, one quotient bit per stage
// depends on ess_pkg
module ess_div #(
  parameter int MW = 4*ess_pkg::ESS_COORD_BITS-1,
  parameter int DW = 2*ess_pkg::ESS_COORD_BITS-2,
  parameter int QW = 2*ess_pkg::ESS_COORD_BITS-2,
  parameter int SW = ess_pkg::ESS_COORD_BITS+2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [MW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);
  import ess_pkg::*;

  logic [QW-1:0] vld_r;
  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] quot_r [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW-1-s;
    logic          src_vld;
    logic [MW-1:0] src_rem, shifted;
    logic [QW-1:0] src_quot;
    logic [DW-1:0] src_den;
    logic [SW-1:0] src_side;
    logic          take;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = in_num;
      assign src_quot = '0;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_quot = quot_r[s-1];
      assign src_den  = den_r[s-1];
      assign src_side = side_r[s-1];
    end

    assign shifted = {{(MW-DW){1'b0}}, src_den} << B;
    assign take    = src_rem >= shifted;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? src_rem - shifted : src_rem;
        quot_r[s] <= take ? (src_quot | (QW'(1) << B)) : src_quot;
        den_r[s]  <= src_den;
        side_r[s] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: hw/rtl/ess_sqrt.sv
// ess_sqrt: pipelined integer square root, one root bit per stage
// depends on ess_pkg
module ess_sqrt #(
  parameter int QW = 2*ess_pkg::ESS_COORD_BITS-2,
  parameter int RW = ess_pkg::ESS_COORD_BITS-1,
  parameter int SW = ess_pkg::ESS_COORD_BITS+2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [QW-1:0] in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic          out_exact,
  output logic [SW-1:0] out_side
);
  import ess_pkg::*;
  localparam int TW = QW+2;

  logic [RW-1:0] vld_r;
  logic [QW-1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] side_r [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int K = RW-1-s;
    logic          src_vld;
    logic [QW-1:0] src_rem;
    logic [RW-1:0] src_root;
    logic [SW-1:0] src_side;
    logic [TW-1:0] delta, rem_ext;
    logic          take;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = in_rad;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_root = root_r[s-1];
      assign src_side = side_r[s-1];
    end

    // (p + 2^k)^2 - p^2 = p*2^(k+1) + 2^(2k)
    assign delta   = (TW'(src_root) << (K+1)) + (TW'(1) << (2*K));
    assign rem_ext = TW'(src_rem);
    assign take    = rem_ext >= delta;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? QW'(rem_ext - delta) : src_rem;
        root_r[s] <= take ? (src_root | (RW'(1) << K)) : src_root;
        side_r[s] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_exact = (rem_r[RW-1] == '0);
  assign out_side  = side_r[RW-1];

endmodule

// File: hw/rtl/ellipse_span_solver_core.sv
// A query passes five front stages, 2*COORD_BITS-2 divider stages, COORD_BITS-1 root
// stages and the output register. Throughput: one query per cycle, set by the
// bit-per-stage divider and root pipelines; the whole pipe holds while a result
// waits unread.
// Reset (synchronous, active low) empties the pipe and loads centre 0, radii 1.
// Config writes are taken in every cycle.
module ellipse_span_solver_core #(
  parameter int COORD_BITS = ess_pkg::ESS_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  ess_in_if.sink    in_ch,
  ess_out_if.source out_ch,
  ess_cfg_if.sink   cfg_ch
);
  import ess_pkg::*;
  localparam int N  = COORD_BITS;
  localparam int MW = 4*N-1;
  localparam int DW = 2*N-2;
  localparam int QW = 2*N-2;
  localparam int RW = N-1;
  localparam int SW = N+2;

  logic signed [N-1:0] cx_r, cy_r;
  logic [N-2:0]        rx_r, ry_r;

  logic                en;
  logic                fr_valid;
  logic [MW-1:0]       fr_num;
  logic [DW-1:0]       fr_den;
  logic signed [N-1:0] fr_cout;
  ess_flags_t          fr_flags;
  logic                dv_valid;
  logic [QW-1:0]       dv_quot;
  logic [SW-1:0]       dv_side;
  logic                sq_valid, sq_exact;
  logic [RW-1:0]       sq_root;
  logic [SW-1:0]       sq_side;

  logic                out_valid_r;
  logic [1:0]          count_r, count_nxt;
  logic signed [N:0]   first_r, first_nxt, second_r, second_nxt;

  logic signed [N-1:0] c_out;
  ess_flags_t          flags;
  logic signed [N:0]   c_ext, r_ext, cpr, cmr, cmr1;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      rx_r <= (N-1)'(1);
      ry_r <= (N-1)'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CENTER_X: cx_r <= cfg_ch.data;
        REG_CENTER_Y: cy_r <= cfg_ch.data;
        REG_RADIUS_X: rx_r <= cfg_ch.data[N-2:0];
        REG_RADIUS_Y: ry_r <= cfg_ch.data[N-2:0];
        default: ;
      endcase
    end
  end

  ess_front #(.COORD_BITS(N)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_ch.valid && en), .in_opcode(in_ch.opcode), .in_coord(in_ch.coordinate),
    .cfg_cx(cx_r), .cfg_cy(cy_r), .cfg_rx(rx_r), .cfg_ry(ry_r),
    .out_valid(fr_valid), .out_num(fr_num), .out_den(fr_den),
    .out_cout(fr_cout), .out_flags(fr_flags)
  );

  ess_div #(.MW(MW), .DW(DW), .QW(QW), .SW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(fr_valid), .in_num(fr_num), .in_den(fr_den),
    .in_side({fr_cout, fr_flags}),
    .out_valid(dv_valid), .out_quot(dv_quot), .out_side(dv_side)
  );

  ess_sqrt #(.QW(QW), .RW(RW), .SW(SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dv_valid), .in_rad(dv_quot), .in_side(dv_side),
    .out_valid(sq_valid), .out_root(sq_root), .out_exact(sq_exact), .out_side(sq_side)
  );

  always_comb begin
    c_out = sq_side[SW-1:2];
    flags = sq_side[1:0];
    c_ext = {c_out[N-1], c_out};
    r_ext = {2'b00, sq_root};
    cpr   = c_ext + r_ext;
    cmr   = c_ext - r_ext;
    cmr1  = cmr - (N+1)'(1);
    count_nxt  = CNT_NONE;
    first_nxt  = '0;
    second_nxt = '0;
    if (flags.neg) begin
      if (flags.near_zero) begin
        count_nxt = CNT_TANGENT;
        first_nxt = c_ext;
      end
    end else if (sq_root == '0) begin
      // zero quotient: tangent at the centre
      count_nxt = CNT_TANGENT;
      first_nxt = c_ext;
    end else begin
      count_nxt = CNT_CHORD;
      if (sq_exact) begin
        first_nxt  = cpr;
        second_nxt = cmr;
      end else begin
        // root lies strictly between r and r+1, truncate toward zero
        first_nxt  = cpr[N] ? cpr + (N+1)'(1) : cpr;
        second_nxt = cmr1[N] ? cmr : cmr1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value_count  = count_r;
  assign out_ch.first_value  = first_r;
  assign out_ch.second_value = second_r;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> count_r != 2'd3) else $error("count out of range");
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r != CNT_CHORD) |-> second_r == '0)
    else $error("second value not cleared");
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r == CNT_NONE) |-> first_r == '0)
    else $error("first value not cleared");
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready) else $error("stalled with empty output");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r) else $error("output valid after reset");
`endif

endmodule

// File: bench/ess_span_checker.sv
`timescale 1ns / 1ps
// ess_span_checker: watches the query, result and config channels of the span solver,
// predicts each result from its own copy of the registers and compares
// depends on ess_pkg and the ess_in_if / ess_out_if / ess_cfg_if interfaces
module ess_span_checker (
  input  logic       clk,
  input  logic       rst_n,
  ess_in_if.sink     in_mon,
  ess_out_if.sink    out_mon,
  ess_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending_spans
);
  import ess_pkg::*;

  typedef struct packed {
    logic [1:0]         count;
    logic signed [12:0] first;
    logic signed [12:0] second;
  } span_t;

  logic signed [11:0] cx, cy;
  logic [10:0]        rx, ry;
  span_t              span_q[$];

  function automatic longint floor_root(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 3000000;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic span_t solve_span(logic op, logic signed [11:0] coord);
    longint ck, co, rd, rm, d, den, num, q, r, f, s;
    span_t res;
    if (op == OP_SOLVE_X) begin
      ck = cy; co = cx; rd = ry; rm = rx;
    end else begin
      ck = cx; co = cy; rd = rx; rm = ry;
    end
    if (rd == 0) rd = 1;
    if (rm == 0) rm = 1;
    d = longint'(coord) - ck;
    den = rd * rd;
    num = rm * rm * (den - d * d);
    q = num / den;
    f = 0;
    s = 0;
    res.count = CNT_NONE;
    if (q == 0) begin
      res.count = CNT_TANGENT;
      f = co;
    end else if (q > 0) begin
      res.count = CNT_CHORD;
      r = floor_root(q);
      if (r * r == q) begin
        f = co + r;
        s = co - r;
      end else begin
        // root lies strictly between r and r+1, truncate toward zero
        f = (co + r >= 0) ? co + r : co + r + 1;
        s = (co - r - 1 >= 0) ? co - r - 1 : co - r;
      end
    end
    res.first = f[12:0];
    res.second = s[12:0];
    return res;
  endfunction

  assign pending_spans = span_q.size();

  always @(posedge clk) begin
    span_t exp_s;
    if (!rst_n) begin
      cx <= '0; cy <= '0; rx <= 11'd1; ry <= 11'd1;
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        span_q.push_back(solve_span(in_mon.opcode, in_mon.coordinate));
      if (out_mon.valid && out_mon.ready) begin
        if (span_q.size() == 0) begin
          $display("%0t: unexpected item count=%0d first=%0d second=%0d", $time,
                   out_mon.value_count, out_mon.first_value, out_mon.second_value);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = span_q.pop_front();
          if (exp_s.count !== out_mon.value_count || exp_s.first !== out_mon.first_value ||
              exp_s.second !== out_mon.second_value) begin
            $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                     exp_s.count, exp_s.first, exp_s.second, out_mon.value_count,
                     out_mon.first_value, out_mon.second_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CENTER_X: cx <= cfg_mon.data;
          REG_CENTER_Y: cy <= cfg_mon.data;
          REG_RADIUS_X: rx <= cfg_mon.data[10:0];
          REG_RADIUS_Y: ry <= cfg_mon.data[10:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: bench/tb_ellipse_span_solver_core.sv
`timescale 1ns / 1ps
// tb_ellipse_span_solver_core: drives queries and register writes into the span solver
// depends on ess_pkg, the channel interfaces, ess_span_checker and the core
module tb_ellipse_span_solver_core;
  import ess_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   fail_count, pending_spans;
  bit   steady;

  ess_in_if  in_ch();
  ess_out_if out_ch();
  ess_cfg_if cfg_ch();

  ellipse_span_solver_core uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                                .cfg_ch(cfg_ch));
  ess_span_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                        .cfg_mon(cfg_ch), .fail_count(fail_count),
                        .pending_spans(pending_spans));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stalls at random except in the steady stretch
  always @(negedge clk)
    out_ch.ready <= steady || ($urandom_range(99) >= 18);

  // valid stays up for the caller to follow with another write
  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // valid stays up so items can follow back to back
  task automatic send_query(logic op, logic [11:0] coord);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.coordinate <= coord;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_spans != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic set_ellipse(logic [11:0] ex, logic [11:0] ey, logic [11:0] ax,
                             logic [11:0] ay);
    write_reg(REG_CENTER_X, ex);
    write_reg(REG_CENTER_Y, ey);
    write_reg(REG_RADIUS_X, ax);
    write_reg(REG_RADIUS_Y, ay);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic op;
    logic signed [11:0] base, rad;
    for (int i = 0; i < n; i++) begin
      op = 1'($urandom_range(1));
      // mostly near the ellipse so chords and tangents dominate
      base = (op == OP_SOLVE_X) ? chk.cy : chk.cx;
      rad = (op == OP_SOLVE_X) ? chk.ry : chk.rx;
      if ($urandom_range(3) == 0)
        send_query(op, 12'($urandom));
      else
        send_query(op, 12'(base + $signed(12'($urandom_range(2 * rad + 2))) - rad - 1));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.opcode = 1'b0; in_ch.coordinate = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset values: unit circle at origin
    send_query(OP_SOLVE_X, 12'sd0);
    send_query(OP_SOLVE_Y, 12'sd1);
    send_query(OP_SOLVE_X, 12'sd2);
    drain();
    set_ellipse(12'd100, -12'sd50, 12'd30, 12'd7);
    send_query(OP_SOLVE_X, -12'sd50);
    send_query(OP_SOLVE_X, -12'sd43);
    send_query(OP_SOLVE_X, -12'sd44);
    send_query(OP_SOLVE_Y, 12'd70);
    send_query(OP_SOLVE_Y, 12'd131);
    send_query(OP_SOLVE_Y, 12'd85);
    send_query(OP_SOLVE_X, 12'h800);
    send_query(OP_SOLVE_X, 12'h7ff);
    drain();
    // extremes, and zero radius treated as one
    set_ellipse(12'h800, 12'h7ff, 12'd2047, 12'd0);
    send_query(OP_SOLVE_X, 12'h7ff);
    send_query(OP_SOLVE_X, 12'h7fe);
    send_query(OP_SOLVE_Y, 12'h800);
    send_query(OP_SOLVE_Y, 12'h7ff);
    send_query(OP_SOLVE_Y, 12'h000);
    send_query(OP_SOLVE_Y, 12'h1ff);
    drain();
    set_ellipse(12'h7ff, 12'h800, 12'hfff, 12'd2047);
    send_query(OP_SOLVE_X, 12'h000);
    send_query(OP_SOLVE_Y, 12'h7ff);
    send_query(OP_SOLVE_Y, 12'h800);
    drain();
    random_phase(150);
    set_ellipse(12'($urandom), 12'($urandom), 12'($urandom_range(1, 60)),
                12'($urandom_range(1, 60)));
    steady = 1'b1;
    random_phase(200);
    steady = 1'b0;
    for (int p = 0; p < 5; p++) begin
      set_ellipse(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      random_phase(140);
    end
    set_ellipse(12'd0, 12'd0, 12'd3, 12'd2047);
    random_phase(30);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
